@@ rtl/min_heap_priority_queue_defines.svh @@
// Assertion macros for the min-heap priority queue.
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked every clock, skipped while reset is asserted.
`define MHPQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mhpq assertion failed");

// Checked every clock, reset included.
`define MHPQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("mhpq assertion failed");

`else

`define MHPQ_ASSERT(lbl, prop)
`define MHPQ_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ rtl/mhpq_pkg.sv @@
// Shared types and constants of the min-heap priority queue.
package mhpq_pkg;

    localparam int KEY_W            = 32;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 8;
    localparam int DEFAULT_CAPACITY = 128;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                    ins;
        logic                    ext;
        logic signed [KEY_W-1:0] value;
    } t_cell_ctrl;

endpackage

@@ rtl/mhpq_cell.sv @@
// One slot of the sorted key row: holds a key, shifts right on insert, left on extract.
module mhpq_cell (
    input  logic                                 i_clk,
    input  mhpq_pkg::t_cell_ctrl                 i_ctrl,
    input  logic                                 i_valid,
    input  logic                                 i_gt_prev,
    input  logic signed [mhpq_pkg::KEY_W-1:0]    i_key_prev,
    input  logic signed [mhpq_pkg::KEY_W-1:0]    i_key_next,
    output logic                                 o_gt,
    output logic signed [mhpq_pkg::KEY_W-1:0]    o_key
);

    logic signed [mhpq_pkg::KEY_W-1:0] r_key;
    logic signed [mhpq_pkg::KEY_W-1:0] n_key;

    // Row is sorted ascending, so the gt flags form a suffix over the held keys.
    assign o_gt  = i_valid && (r_key > i_ctrl.value);
    assign o_key = r_key;

    always_comb begin
        n_key = r_key;
        if (i_ctrl.ins) begin
            if (i_gt_prev) begin
                n_key = i_key_prev;
            end else if (o_gt || !i_valid) begin
                n_key = i_ctrl.value;
            end
        end else if (i_ctrl.ext) begin
            n_key = i_key_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

@@ rtl/min_heap_priority_queue.sv @@
// Top level of the min-heap priority queue: a sorted row of key cells.
//
// Usage:
//   Command channel: drive i_op and i_value with start high; the beat is
//   taken at a rising edge where busy is low. i_op = insert adds i_value,
//   i_op = extract removes the smallest key held.
//   Result channel: o_done is high for exactly one cycle, the cycle right
//   after the command beat, with o_min_value, o_status and o_count.
//   o_min_value is the removed key, zero for inserts and errors. o_status
//   is ok, empty (extract with nothing held) or full (insert dropped).
//   o_count is the number of keys held after the command, low 8 bits.
// Throughput: one command every cycle while busy is low.
//   Every cell compares its key with the command key at once and takes
//   its own key, the new key or a neighbor's key; the row stays sorted,
//   so cell 0 always holds the minimum.
// Reset: synchronous, active low; the fill count clears and busy is high
//   while reset is held and for the cycle after. Cell contents are not
//   cleared; cells at or beyond the fill count are ignored.
// The receiver cannot stall: results must be taken when o_done is high.
module min_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic                                  i_op,
    input  logic signed [mhpq_pkg::KEY_W-1:0]     i_value,
    output logic                                  busy,
    output logic                                  o_done,
    output logic signed [mhpq_pkg::KEY_W-1:0]     o_min_value,
    output logic        [mhpq_pkg::STATUS_W-1:0]  o_status,
    output logic        [mhpq_pkg::COUNT_W-1:0]   o_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Control state
    logic          r_busy;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_done;

    // Result payload
    logic signed [mhpq_pkg::KEY_W-1:0]    r_min;
    logic signed [mhpq_pkg::KEY_W-1:0]    n_min;
    logic        [mhpq_pkg::STATUS_W-1:0] r_status;
    logic        [mhpq_pkg::STATUS_W-1:0] n_status;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    mhpq_pkg::t_cell_ctrl w_ctrl;
    logic [CW+mhpq_pkg::COUNT_W-1:0] w_count_ext;

    logic signed [mhpq_pkg::KEY_W-1:0] w_key   [CAPACITY];
    logic                              w_gt    [CAPACITY];
    logic                              w_valid [CAPACITY];

    assign busy     = r_busy | ~i_rst_n;
    assign w_accept = start & ~busy;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // Command fanned out to the whole row; dropped commands move nothing.
    always_comb begin
        w_ctrl.ins   = w_accept && (i_op == mhpq_pkg::OP_INSERT) && !w_full;
        w_ctrl.ext   = w_accept && (i_op == mhpq_pkg::OP_EXTRACT) && !w_empty;
        w_ctrl.value = i_value;
    end

    // Row of cells; a cell is live while its index is below the fill count.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                              w_gt_prev;
        logic signed [mhpq_pkg::KEY_W-1:0] w_key_prev;
        logic signed [mhpq_pkg::KEY_W-1:0] w_key_next;

        assign w_valid[g] = (r_count > CW'(g));

        if (g == 0) begin : g_head
            assign w_gt_prev  = 1'b0;
            assign w_key_prev = i_value;
        end else begin : g_body
            assign w_gt_prev  = w_gt[g-1];
            assign w_key_prev = w_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_key_next = i_value;   // slot goes dead on extract
        end else begin : g_link
            assign w_key_next = w_key[g+1];
        end

        mhpq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_valid    (w_valid[g]),
            .i_gt_prev  (w_gt_prev),
            .i_key_prev (w_key_prev),
            .i_key_next (w_key_next),
            .o_gt       (w_gt[g]),
            .o_key      (w_key[g])
        );
    end

    // Result and fill count
    always_comb begin
        n_count  = r_count;
        n_min    = '0;
        n_status = mhpq_pkg::ST_OK;
        if (i_op == mhpq_pkg::OP_INSERT) begin
            if (w_full) begin
                n_status = mhpq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = mhpq_pkg::ST_EMPTY;
            end else begin
                n_min   = w_key[0];
                n_count = r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_busy <= 1'b0;
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_min    <= n_min;
            r_status <= n_status;
        end
    end

    assign w_count_ext = {{mhpq_pkg::COUNT_W{1'b0}}, r_count};

    assign o_done      = r_done;
    assign o_min_value = r_min;
    assign o_status    = r_status;
    assign o_count     = w_count_ext[mhpq_pkg::COUNT_W-1:0];

    // Assertions
`include "min_heap_priority_queue_defines.svh"

    `MHPQ_ASSERT(a_count_bound, (r_count <= CW'(CAPACITY)))
    `MHPQ_ASSERT(a_done_follows_beat, (w_accept |=> o_done))
    `MHPQ_ASSERT_ALWAYS(a_no_stray_done, (!(w_accept && i_rst_n) |=> !o_done))
    `MHPQ_ASSERT(a_extract_takes_head, (w_ctrl.ext |=> (o_min_value == $past(w_key[0]))))

endmodule
